// ===== sv/scatter_reduce_table_macros.svh =====
// Assertion macros shared by the scatter-reduce table RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SCATTER_REDUCE_TABLE_MACROS_SVH
`define SCATTER_REDUCE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/srt_pkg.sv =====
// Package for the scatter-reduce table: codes, defaults, state and link types.
// Used by srt_alu and scatter_reduce_table; depends on nothing.
package srt_pkg;

  localparam int ROWS_DEF       = 1024;
  localparam int COLS_DEF       = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Scatter operations held in the op_mode register.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAX = 3'd4;
  localparam logic [2:0] OP_MIN = 3'd5;
  localparam logic [2:0] OP_SET = 3'd6;

  // Commands carried in the input word's tuser.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_SCATTER = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_COL  = 2'd2;
  localparam logic [1:0] ST_DIV0 = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_OP_MODE     = 2'd0;
  localparam logic [1:0] REG_ROWS_IN_USE = 2'd1;
  localparam logic [1:0] REG_COLS_IN_USE = 2'd2;

  localparam int CFG_ADDR_W  = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EXEC,
    S_ALU,
    S_RESP
  } ctl_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_SIMPLE,
    A_MUL,
    A_ABSA,
    A_ABSB,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

// ===== sv/scatter_reduce_table.sv =====
// One word is handled at a time: in_tready is low from the accepting edge until the result
// enters the output register, and returns in the same cycle that out_tvalid rises; a full
// output register holds the result back. A range error is answered straight from the check;
// multiply and divide run iteratively in the ALU. The shared ALU and the single
// table RAM (read, then write back) set the pace. Reset (rst_n, synchronous) clears the
// control state and sets op_mode to add, rows_in_use to 1024 and cols_in_use to 64.
`include "scatter_reduce_table_macros.svh"

module scatter_reduce_table #(
  parameter int ROWS       = srt_pkg::ROWS_DEF,
  parameter int COLS       = srt_pkg::COLS_DEF,
  parameter int DATA_WIDTH = srt_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: row_index [31:0], column [37:32], update_value [69:38], zero fill [71:70]
  input  logic [srt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: command [1:0]
  input  logic [1:0]                         in_tuser,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: element_value [31:0]
  output logic [srt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: status [1:0]
  output logic [1:0]                         out_tuser,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [srt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. A write lands on the access cycle; pready is tied
  // high so every access completes at once. Addresses past the last register
  // are ignored on write and read as zero.
  // ---------------------------------------------------------------------------
  logic [2:0]  op_mode_r;
  logic [10:0] rows_in_use_r;
  logic [6:0]  cols_in_use_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r     <= srt_pkg::OP_ADD;
      rows_in_use_r <= 11'd1024;
      cols_in_use_r <= 7'd64;
    end else if (cfg_wr) begin
      case (cfg_idx)
        srt_pkg::REG_OP_MODE:     op_mode_r     <= cfg_pwdata[2:0];
        srt_pkg::REG_ROWS_IN_USE: rows_in_use_r <= cfg_pwdata[10:0];
        srt_pkg::REG_COLS_IN_USE: cols_in_use_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      srt_pkg::REG_OP_MODE:     cfg_prdata = 32'(op_mode_r);
      srt_pkg::REG_ROWS_IN_USE: cfg_prdata = 32'(rows_in_use_r);
      srt_pkg::REG_COLS_IN_USE: cfg_prdata = 32'(cols_in_use_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. A word is captured in idle, range-checked while the table read
  // is issued, then loaded, read or combined through the shared ALU, written
  // back, and handed to the output register.
  // ---------------------------------------------------------------------------
  srt_pkg::ctl_state_t state_r, state_nxt;

  logic [1:0]            cmd_r, cmd_nxt;
  logic [31:0]           row_r, row_nxt;
  logic [5:0]            col_r, col_nxt;
  logic [DATA_WIDTH-1:0] upd_r, upd_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [DATA_WIDTH-1:0] res_val_r, res_val_nxt;
  logic [1:0]            res_st_r, res_st_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;

  logic                  in_acc;
  logic                  row_bad, col_bad;
  logic [ADDR_W-1:0]     elem_addr;
  logic                  out_free;

  logic                  ram_we, ram_re;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  srt_pkg::alu_ctl_t     alu_ctl;
  srt_pkg::alu_stat_t    alu_stat;
  logic [DATA_WIDTH-1:0] alu_result;

  assign in_tready = (state_r == srt_pkg::S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  // A negative row, or one past either limit, is refused before the column.
  assign row_bad = row_r[31] || (row_r >= 32'(rows_in_use_r)) || (row_r >= 32'(ROWS));
  assign col_bad = ({1'b0, col_r} >= cols_in_use_r) || (32'(col_r) >= 32'(COLS));

  // Row-major element address; only used once the row and column are in range.
  assign elem_addr = ADDR_W'(32'(row_r[ROW_W-1:0]) * 32'(COLS) + 32'(col_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    upd_r      <= upd_nxt;
    addr_r     <= addr_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    upd_nxt       = upd_r;
    addr_nxt      = addr_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = upd_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = op_mode_r;

    case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_tuser;
          row_nxt   = in_tdata[31:0];
          col_nxt   = in_tdata[37:32];
          // The 32-bit update is sign-extended or cut to the element width.
          upd_nxt   = DATA_WIDTH'($signed(in_tdata[69:38]));
          state_nxt = srt_pkg::S_CHECK;
        end
      end

      srt_pkg::S_CHECK: begin
        res_val_nxt = '0;
        if (row_bad) begin
          res_st_nxt = srt_pkg::ST_ROW;
          state_nxt  = srt_pkg::S_RESP;
        end else if (col_bad) begin
          res_st_nxt = srt_pkg::ST_COL;
          state_nxt  = srt_pkg::S_RESP;
        end else begin
          ram_re    = 1'b1;
          addr_nxt  = elem_addr;
          state_nxt = srt_pkg::S_EXEC;
        end
      end

      srt_pkg::S_EXEC: begin
        res_st_nxt = srt_pkg::ST_OK;
        case (cmd_r)
          srt_pkg::CMD_LOAD: begin
            ram_we      = 1'b1;
            res_val_nxt = upd_r;
            state_nxt   = srt_pkg::S_RESP;
          end
          srt_pkg::CMD_SCATTER: begin
            if ((op_mode_r == srt_pkg::OP_DIV) && (upd_r == '0)) begin
              res_val_nxt = ram_rdata;
              res_st_nxt  = srt_pkg::ST_DIV0;
              state_nxt   = srt_pkg::S_RESP;
            end else begin
              alu_ctl.start = 1'b1;
              state_nxt     = srt_pkg::S_ALU;
            end
          end
          default: begin
            // A read, and the unused command code, return the element.
            res_val_nxt = ram_rdata;
            state_nxt   = srt_pkg::S_RESP;
          end
        endcase
      end

      srt_pkg::S_ALU: begin
        if (alu_stat.done) begin
          ram_we      = 1'b1;
          ram_wdata   = alu_result;
          res_val_nxt = alu_result;
          state_nxt   = srt_pkg::S_RESP;
        end
      end

      srt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'(res_val_r);
          out_user_nxt  = res_st_r;
          state_nxt     = srt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = srt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  srt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (elem_addr),
    .rdata (ram_rdata)
  );

  srt_alu #(
    .DW (DATA_WIDTH)
  ) u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (alu_ctl),
    .a_i      (ram_rdata),
    .b_i      (upd_r),
    .result_o (alu_result),
    .stat     (alu_stat)
  );

  // The table is written only by a load or by a finished combine.
  `SRT_ASSERT_SAME(a_we_state, ram_we, (state_r == srt_pkg::S_EXEC) || (state_r == srt_pkg::S_ALU), "table write outside execute")
  // The ALU is never started while it is still working on an earlier word.
  `SRT_ASSERT_SAME(a_alu_free, alu_ctl.start, !alu_stat.busy, "ALU started while busy")
  // A finished result waits while the output register is still occupied.
  `SRT_ASSERT_NEXT(a_resp_hold, (state_r == srt_pkg::S_RESP) && out_valid_r && !out_tready, state_r == srt_pkg::S_RESP, "result dropped")

endmodule

// ===== sv/srt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module srt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/srt_alu.sv =====
// Shared iterative arithmetic unit of the scatter-reduce table: one adder
// serves add, subtract, compare, shift-add multiply and restoring divide.
// Depends on srt_pkg and scatter_reduce_table_macros.svh.
`include "scatter_reduce_table_macros.svh"

module srt_alu #(
  parameter int DW = srt_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srt_pkg::alu_ctl_t   ctl,
  input  logic [DW-1:0]       a_i,
  input  logic [DW-1:0]       b_i,
  output logic [DW-1:0]       result_o,
  output srt_pkg::alu_stat_t  stat
);

  localparam int XW = DW + 2;
  localparam int CW = $clog2(DW);

  srt_pkg::alu_state_t st_r, st_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] opa_r, opa_nxt;
  logic [DW-1:0] opb_r, opb_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [2:0]    op_r, op_nxt;

  logic [XW-1:0] add_x, add_y, sum;
  logic          add_sub;
  logic          last_step;

  // The one adder of the unit; subtraction inverts the second operand.
  assign sum = add_x + (add_y ^ {XW{add_sub}}) + XW'(add_sub);
  assign last_step = (cnt_r == CW'(DW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= srt_pkg::A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    op_r  <= op_nxt;
  end

  always_comb begin
    st_nxt  = st_r;
    acc_nxt = acc_r;
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    op_nxt  = op_r;
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;

    case (st_r)
      srt_pkg::A_IDLE: begin
        if (ctl.start) begin
          opa_nxt = a_i;
          opb_nxt = b_i;
          op_nxt  = ctl.op;
          acc_nxt = '0;
          cnt_nxt = '0;
          case (ctl.op)
            srt_pkg::OP_MUL: st_nxt = srt_pkg::A_MUL;
            srt_pkg::OP_DIV: st_nxt = srt_pkg::A_ABSA;
            default:         st_nxt = srt_pkg::A_SIMPLE;
          endcase
        end
      end

      srt_pkg::A_SIMPLE: begin
        case (op_r)
          srt_pkg::OP_ADD, srt_pkg::OP_SUB: begin
            add_x   = {{2{opa_r[DW-1]}}, opa_r};
            add_y   = {{2{opb_r[DW-1]}}, opb_r};
            add_sub = (op_r == srt_pkg::OP_SUB);
          end
          default: begin
            // b - a is negative exactly when a is greater than b.
            add_x   = {{2{opb_r[DW-1]}}, opb_r};
            add_y   = {{2{opa_r[DW-1]}}, opa_r};
            add_sub = 1'b1;
          end
        endcase
        case (op_r)
          srt_pkg::OP_ADD, srt_pkg::OP_SUB: acc_nxt = sum[DW-1:0];
          srt_pkg::OP_MAX: acc_nxt = sum[XW-1] ? opa_r : opb_r;
          srt_pkg::OP_MIN: acc_nxt = sum[XW-1] ? opb_r : opa_r;
          srt_pkg::OP_SET: acc_nxt = opb_r;
          default:         acc_nxt = opa_r;
        endcase
        st_nxt = srt_pkg::A_DONE;
      end

      srt_pkg::A_MUL: begin
        add_x = {2'b00, acc_r};
        add_y = {2'b00, opa_r};
        if (opb_r[0]) begin
          acc_nxt = sum[DW-1:0];
        end
        opa_nxt = {opa_r[DW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[DW-1:1]};
        cnt_nxt = cnt_r + CW'(1);
        if (last_step) begin
          st_nxt = srt_pkg::A_DONE;
        end
      end

      srt_pkg::A_ABSA: begin
        neg_nxt = opa_r[DW-1] ^ opb_r[DW-1];
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
        if (opa_r[DW-1]) begin
          opa_nxt = sum[DW-1:0];
        end
        st_nxt = srt_pkg::A_ABSB;
      end

      srt_pkg::A_ABSB: begin
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
        if (opb_r[DW-1]) begin
          opb_nxt = sum[DW-1:0];
        end
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = srt_pkg::A_DIV;
      end

      srt_pkg::A_DIV: begin
        // Restoring step: the quotient bit shifts in as the dividend shifts out.
        add_x   = {1'b0, rem_r, opa_r[DW-1]};
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
        if (sum[XW-1]) begin
          rem_nxt = {rem_r[DW-2:0], opa_r[DW-1]};
        end else begin
          rem_nxt = sum[DW-1:0];
        end
        opa_nxt = {opa_r[DW-2:0], ~sum[XW-1]};
        cnt_nxt = cnt_r + CW'(1);
        if (last_step) begin
          st_nxt = srt_pkg::A_FIX;
        end
      end

      srt_pkg::A_FIX: begin
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
        acc_nxt = neg_r ? sum[DW-1:0] : opa_r;
        st_nxt  = srt_pkg::A_DONE;
      end

      srt_pkg::A_DONE: begin
        st_nxt = srt_pkg::A_IDLE;
      end

      default: begin
        st_nxt = srt_pkg::A_IDLE;
      end
    endcase
  end

  assign result_o  = acc_r;
  assign stat.busy = (st_r != srt_pkg::A_IDLE);
  assign stat.done = (st_r == srt_pkg::A_DONE);

  `SRT_ASSERT_SAME(a_start_idle, ctl.start, st_r == srt_pkg::A_IDLE, "ALU started while busy")
  `SRT_ASSERT_SAME(a_div_nonzero, st_r == srt_pkg::A_DIV, opb_r != '0, "divide step with zero divisor")
  `SRT_ASSERT_NEXT(a_done_once, st_r == srt_pkg::A_DONE, st_r == srt_pkg::A_IDLE, "ALU done held")

endmodule
